>>> sv/rpg_pkg.sv
// Package for the record pattern generator/checker: constants, codes and item types.
package rpg_pkg;

   // Sizing of the name store and of a record.
   localparam int NAME_DEPTH   = 256;
   localparam int RECORD_WORDS = 2113;
   localparam int NAME_AW      = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
   localparam int NAME_CAP     = (NAME_DEPTH < RECORD_WORDS - 2) ? NAME_DEPTH
                                                                 : RECORD_WORDS - 2;

   // Field widths.
   localparam int WORD_W  = 32;
   localparam int POS_W   = 12;
   localparam int INDEX_W = 8;
   localparam int NAMES_W = 9;

   // Generator coefficients.
   localparam logic [WORD_W-1:0] LCG_MUL = 32'd3141592621;
   localparam logic [WORD_W-1:0] LCG_ADD = 32'd2818281829;

   // Register map.
   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_SEED  = 2'd1,
      CSR_NAMES = 2'd2
   } csr_index_type;

   // Word kinds / error codes.
   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_NAME   = 2'd1,
      ERR_RECORD = 2'd2,
      ERR_DATA   = 2'd3
   } err_kind_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_WORD = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic               req_type;
      logic [INDEX_W-1:0] name_index;
      logic [WORD_W-1:0]  word_in;
      logic               end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] expected_word;
      logic [1:0]        error_kind;
      logic              error_latched;
      logic [WORD_W-1:0] record_number;
      logic [POS_W-1:0]  word_position;
   } rsp_item_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic               mode;
      logic [WORD_W-1:0]  seed_start;
      logic [NAMES_W-1:0] name_words;
   } cfg_type;

   // Item between the sequencer and the checker, aligned with the name read data.
   typedef struct packed {
      logic              is_load;
      err_kind_type      sel;
      logic [WORD_W-1:0] word_in;
      logic              eos;
      logic [WORD_W-1:0] exp_word;
      logic [WORD_W-1:0] record_number;
      logic [POS_W-1:0]  word_position;
   } stage_type;

endpackage

>>> sv/rpg_ram.sv
// Generic simple dual-port RAM with registered read.
module rpg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/rpg_seq.sv
// Record sequencer: position, record number and generator, name store addressing.
module rpg_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  rpg_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   input  rpg_pkg::req_item_type    req_data,
   output logic                     req_stall,
   input  logic                     s1_take,
   output logic                     s1_valid,
   output rpg_pkg::stage_type       s1_data,
   output logic                     ram_we,
   output logic [rpg_pkg::NAME_AW-1:0] ram_waddr,
   output logic [rpg_pkg::WORD_W-1:0]  ram_wdata,
   output logic                     ram_re,
   output logic [rpg_pkg::NAME_AW-1:0] ram_raddr
);
   import rpg_pkg::*;

   logic [WORD_W-1:0] gen_ff, gen_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] rec_ff, rec_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;

   logic [POS_W-1:0]  names_eff;
   logic [WORD_W-1:0] gen_next;
   logic [WORD_W-1:0] rec_next;
   logic              accept;
   logic              is_word;
   logic              rec_end;
   err_kind_type      sel;

   // Effective name count: zero counts as one, capped by store and record size.
   always_comb begin
      names_eff = POS_W'(cfg.name_words);
      if (cfg.name_words == '0) begin
         names_eff = POS_W'(1);
      end
      if (names_eff > POS_W'(NAME_CAP)) begin
         names_eff = POS_W'(NAME_CAP);
      end
   end

   assign req_stall = s1_valid_ff && !s1_take;
   assign accept    = req_valid && !req_stall;
   assign is_word   = (req_data.req_type == REQ_WORD);
   assign gen_next  = LCG_MUL * gen_ff + LCG_ADD;
   assign rec_end   = ({1'b0, pos_ff} + 1'b1) >= (POS_W + 1)'(RECORD_WORDS);
   assign rec_next  = (rec_ff == '1) ? WORD_W'(1) : rec_ff + 1'b1;

   // Which part of the record this position falls in.
   always_comb begin
      priority if (pos_ff < names_eff) begin
         sel = ERR_NAME;
      end else if (pos_ff == names_eff) begin
         sel = ERR_RECORD;
      end else begin
         sel = ERR_DATA;
      end
   end

   // Name store access: loads write, name positions read.
   assign ram_we    = accept && !is_word && ({24'b0, req_data.name_index} < NAME_DEPTH);
   assign ram_waddr = NAME_AW'(req_data.name_index);
   assign ram_wdata = req_data.word_in;
   assign ram_re    = accept && is_word && (sel == ERR_NAME);
   assign ram_raddr = NAME_AW'(pos_ff);

   // Sequencer state and the stage register.
   always_comb begin
      gen_in      = gen_ff;
      pos_in      = pos_ff;
      rec_in      = rec_ff;
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_take) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in         = 1'b1;
         s1_in.is_load       = !is_word;
         s1_in.sel           = sel;
         s1_in.word_in       = req_data.word_in;
         s1_in.eos           = req_data.end_of_stream;
         s1_in.record_number = rec_ff;
         s1_in.word_position = pos_ff;
         s1_in.exp_word      = (sel == ERR_DATA) ? gen_next : rec_ff;
         if (is_word) begin
            if (sel == ERR_DATA) begin
               gen_in = gen_next;
            end
            priority if (req_data.end_of_stream) begin
               gen_in = cfg.seed_start;
               pos_in = '0;
               rec_in = WORD_W'(1);
            end else if (rec_end) begin
               pos_in = '0;
               rec_in = rec_next;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         pos_ff      <= '0;
         rec_ff      <= WORD_W'(1);
         s1_valid_ff <= 1'b0;
      end else begin
         gen_ff      <= gen_in;
         pos_ff      <= pos_in;
         rec_ff      <= rec_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

endmodule

>>> sv/rpg_check.sv
// Compare stage: picks the expected word, checks it, keeps the error flag, output register.
module rpg_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mode,
   input  logic                       s1_valid,
   input  rpg_pkg::stage_type         s1_data,
   input  logic [rpg_pkg::WORD_W-1:0] ram_rdata,
   output logic                       s1_take,
   output logic                       rsp_valid,
   output rpg_pkg::rsp_item_type      rsp_data,
   input  logic                       rsp_stall
);
   import rpg_pkg::*;

   logic         flag_ff, flag_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [WORD_W-1:0] expect_word;
   err_kind_type      kind;
   logic              flag_next;
   logic              advance;

   assign s1_take = !rsp_valid_ff || !rsp_stall;
   assign advance = s1_valid && s1_take;

   // Expected word and mismatch classification.
   assign expect_word = (s1_data.sel == ERR_NAME) ? ram_rdata : s1_data.exp_word;
   always_comb begin
      kind = s1_data.sel;
      if (s1_data.is_load || !mode || (s1_data.word_in == expect_word)) begin
         kind = ERR_NONE;
      end
   end
   assign flag_next = flag_ff || (kind != ERR_NONE);

   always_comb begin
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_take) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_in.expected_word = s1_data.is_load ? '0 : expect_word;
         rsp_in.error_kind    = kind;
         rsp_in.error_latched = flag_next;
         rsp_in.record_number = s1_data.record_number;
         rsp_in.word_position = s1_data.word_position;
         // End of stream on a data word clears the flag after reporting it.
         flag_in = (s1_data.eos && !s1_data.is_load) ? 1'b0 : flag_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_err_latched : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.error_kind != ERR_NONE) |-> rsp_ff.error_latched)
      else $error("reported error without latched flag");

   a_eos_clears : assert property (@(posedge clock) disable iff (reset)
      advance && s1_data.eos && !s1_data.is_load |=> !flag_ff)
      else $error("end of stream did not clear error flag");

   a_load_quiet : assert property (@(posedge clock) disable iff (reset)
      advance && s1_data.is_load |=> (rsp_ff.error_kind == ERR_NONE)
                                     && (rsp_ff.expected_word == '0))
      else $error("load item reported a word or an error");

endmodule

>>> sv/record_pattern_gen_check.sv
// Top level: record pattern generator/checker with register file.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) carries one item per word:
//    a load writes one name-table slot, a data item is a generate tick or a
//    word to check. Every item, loads included, yields one rsp item.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data) returns the expected word,
//    error kind, latched error flag, record number and word position.
//  - csr port: csr_we writes csr_wdata into register csr_index (mode,
//    seed_start, name_words); write only while no item is in flight.
// Path: req accept, then the sequencer stage with the name-table read, then
// compare into the output register.
// Throughput: 1 item per cycle while rsp does not stall; the generator update
// (one 32x32 multiply and add) is combinational from its register, and the name table has separate
// read and write ports.
// Stall: a stalled rsp holds its item; the sequencer stage still takes one
// more item, then req_stall rises until rsp moves.
// Reset: position 0, record number 1, generator 0, flag clear, registers at
// defaults; the name table is undefined until loaded (no clearing pass).
module record_pattern_gen_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rpg_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rpg_pkg::rsp_item_type rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import rpg_pkg::*;

   logic               mode_ff, mode_in;
   logic [WORD_W-1:0]  seed_ff, seed_in;
   logic [NAMES_W-1:0] names_ff, names_in;

   cfg_type             cfg;
   logic                s1_valid;
   logic                s1_take;
   stage_type           s1_data;
   logic                ram_we;
   logic                ram_re;
   logic [NAME_AW-1:0]  ram_waddr;
   logic [NAME_AW-1:0]  ram_raddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [WORD_W-1:0]   ram_rdata;

   // Register file.
   always_comb begin
      mode_in  = mode_ff;
      seed_in  = seed_ff;
      names_in = names_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:  mode_in  = csr_wdata[0];
            CSR_SEED:  seed_in  = csr_wdata;
            CSR_NAMES: names_in = csr_wdata[NAMES_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         seed_ff  <= '0;
         names_ff <= NAMES_W'(1);
      end else begin
         mode_ff  <= mode_in;
         seed_ff  <= seed_in;
         names_ff <= names_in;
      end
   end

   assign cfg.mode       = mode_ff;
   assign cfg.seed_start = seed_ff;
   assign cfg.name_words = names_ff;

   rpg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .s1_take   (s1_take),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr)
   );

   rpg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NAME_DEPTH),
      .AW    (NAME_AW)
   ) u_name_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rpg_check u_check (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .ram_rdata (ram_rdata),
      .s1_take   (s1_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for record_pattern_gen_check: directed and random items against a predictor.
module tb;
   import rpg_pkg::*;

   // Per-stream pattern state, one copy for checking and one for planning stimulus.
   typedef struct packed {
      logic [WORD_W-1:0] lcg;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] rec;
      logic              flag;
   } stream_state_type;

   localparam int CHECKER    = 0;
   localparam int PLANNER    = 1;
   localparam int HOLD_LEN   = 150;
   localparam int RAND_ITEMS = 480;

   logic         clock;
   logic         reset;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   record_pattern_gen_check dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfg_type           cfg_now;
   stream_state_type  stream [2];
   logic [WORD_W-1:0] name_copy [2][NAME_DEPTH];
   bit                slot_loaded [NAME_DEPTH];
   req_item_type      word_backlog [$];
   rsp_item_type      pending_results [$];
   int unsigned       items_queued = 0;
   int unsigned       results_seen = 0;
   int unsigned       fail_count = 0;
   bit                req_fire = 1'b0;
   bit                rsp_fire = 1'b0;
   int unsigned       req_gap = 0;
   int unsigned       rsp_wait = 0;
   int unsigned       hold_left = 0;
   int unsigned       hold_asks = 0;
   int unsigned       hold_done = 0;
   bit                hold_on = 1'b0;
   bit                req_calm = 1'b0;
   bit                rsp_calm = 1'b0;
   bit                rush = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Name words per record after clamping: zero counts as one, capped by table and record.
   function automatic int unsigned name_span(cfg_type c);
      int unsigned n;
      n = c.name_words;
      if (n == 0) n = 1;
      if (n > NAME_CAP) n = NAME_CAP;
      return n;
   endfunction

   // Result of one item on the chosen state copy; updates that copy.
   function automatic rsp_item_type pattern_result(int which, req_item_type it);
      int unsigned       names;
      stream_state_type  s;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] want;
      err_kind_type      kind;
      rsp_item_type      r;
      names = name_span(cfg_now);
      s     = stream[which];
      pos   = s.pos;
      // load: 8-bit index always fits the table; end marker ignored
      if (it.req_type == REQ_LOAD) begin
         name_copy[which][it.name_index] = it.word_in;
         r.expected_word = '0;
         r.error_kind    = ERR_NONE;
         r.error_latched = s.flag;
         r.record_number = s.rec;
         r.word_position = pos;
         return r;
      end
      if (pos < names) begin
         want = name_copy[which][pos[INDEX_W-1:0]];
         kind = ERR_NAME;
      end else if (pos == names) begin
         want = s.rec;
         kind = ERR_RECORD;
      end else begin
         s.lcg = s.lcg * LCG_MUL + LCG_ADD;
         want  = s.lcg;
         kind  = ERR_DATA;
      end
      if (!cfg_now.mode || it.word_in == want) kind = ERR_NONE;
      if (kind != ERR_NONE) s.flag = 1'b1;
      r.expected_word = want;
      r.error_kind    = kind;
      r.error_latched = s.flag;
      r.record_number = s.rec;
      r.word_position = pos;
      // restart, record wrap (counter skips zero), or advance
      if (it.end_of_stream) begin
         s.lcg  = cfg_now.seed_start;
         s.pos  = '0;
         s.rec  = 1;
         s.flag = 1'b0;
      end else if (int'(pos) + 1 >= RECORD_WORDS) begin
         s.pos = '0;
         s.rec = s.rec + 1;
         if (s.rec == 0) s.rec = 1;
      end else begin
         s.pos = pos + 1'b1;
      end
      stream[which] = s;
      return r;
   endfunction

   function automatic void queue_item(req_item_type it);
      void'(pattern_result(PLANNER, it));
      word_backlog.push_back(it);
      items_queued++;
   endfunction

   function automatic void send_load(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] word,
                                     logic eos);
      req_item_type it;
      it.req_type      = REQ_LOAD;
      it.name_index    = idx;
      it.word_in       = word;
      it.end_of_stream = eos;
      slot_loaded[idx] = 1'b1;
      queue_item(it);
   endfunction

   // Data word: correct pattern word xor flip in check mode, random in generate mode.
   // A name slot about to be read is loaded first if it never was.
   function automatic void send_word(logic eos, logic [WORD_W-1:0] flip);
      req_item_type     it;
      stream_state_type keep;
      rsp_item_type     r;
      if (stream[PLANNER].pos < name_span(cfg_now) &&
          !slot_loaded[stream[PLANNER].pos[INDEX_W-1:0]])
         send_load(stream[PLANNER].pos[INDEX_W-1:0], $urandom, 1'($urandom_range(0, 1)));
      it.req_type      = REQ_WORD;
      it.name_index    = INDEX_W'($urandom);
      it.end_of_stream = eos;
      it.word_in       = '0;
      keep = stream[PLANNER];
      r    = pattern_result(PLANNER, it);
      stream[PLANNER] = keep;
      it.word_in = cfg_now.mode ? (r.expected_word ^ flip) : $urandom;
      queue_item(it);
   endfunction

   // Every item gives one result, so idle means all results are back.
   task automatic wait_idle();
      while (results_seen != items_queued) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODE:  cfg_now.mode       = val[0];
         CSR_SEED:  cfg_now.seed_start = val;
         CSR_NAMES: cfg_now.name_words = val[NAMES_W-1:0];
         default:   ;
      endcase
   endtask

   task automatic set_config(logic m, logic [31:0] seed, logic [NAMES_W-1:0] names);
      wait_idle();
      write_csr(CSR_MODE, {31'd0, m});
      write_csr(CSR_SEED, seed);
      write_csr(CSR_NAMES, {23'd0, names});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Sender: one item per handshake, random gap before each item.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (word_backlog.size() > 0) begin
            req_data  <= word_backlog.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            req_gap = (req_calm || rush) ? 0 : $urandom_range(0, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted in cycles on request.
   always @(negedge clock) begin : hold_off
      if (reset) begin
         hold_left = 0;
         hold_on  <= 1'b0;
      end else begin
         if (hold_done != hold_asks) begin
            hold_left = HOLD_LEN;
            hold_done = hold_asks;
         end
         hold_on <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   // Receiver: random stall per item, plus the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 11);
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predict on accepted items, compare accepted results in order.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire) pending_results.push_back(pattern_result(CHECKER, req_data));
      if (rsp_fire) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: result with no item outstanding: word %h", $time,
                        rsp_data.expected_word);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.expected_word !== want.expected_word ||
                rsp_data.error_kind    !== want.error_kind    ||
                rsp_data.error_latched !== want.error_latched ||
                rsp_data.record_number !== want.record_number ||
                rsp_data.word_position !== want.word_position) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result differs: exp word %h kind %0d latched %b rec %0d pos %0d",
                           $time, want.expected_word, want.error_kind, want.error_latched,
                           want.record_number, want.word_position);
                  $display("   got word %h kind %0d latched %b rec %0d pos %0d",
                           rsp_data.expected_word, rsp_data.error_kind,
                           rsp_data.error_latched, rsp_data.record_number,
                           rsp_data.word_position);
               end
            end
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned       random_items;
      int unsigned       start_count;
      int unsigned       len;
      int unsigned       pick;
      bit                first;
      logic [WORD_W-1:0] flip;
      logic [WORD_W-1:0] seed;
      logic [NAMES_W-1:0] names;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_MODE;
      csr_wdata = '0;
      cfg_now   = '{mode: 1'b0, seed_start: '0, name_words: NAMES_W'(1)};
      for (int i = 0; i < 2; i++) stream[i] = '{lcg: '0, pos: '0, rec: 1, flag: 1'b0};
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // register defaults; end marker on a load is ignored
      send_load(8'd0, 32'hFFFF_FFFF, 1'b1);
      send_load(8'd255, 32'h0, 1'b0);
      send_word(1'b0, '0);
      send_word(1'b0, '0);
      send_word(1'b0, '0);
      send_word(1'b1, '0);

      // check mode, zero name count counts as one; each error kind, latching, restart
      set_config(1'b1, 32'hFFFF_FFFF, 9'd0);
      send_word(1'b0, '0);
      send_word(1'b0, 32'hFFFF_FFFF);
      send_word(1'b0, '0);
      send_word(1'b0, 32'h1);
      send_word(1'b1, '0);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b0, '0);
      send_word(1'b1, '0);

      // two name words, stream left open mid-record
      set_config(1'b1, 32'h0, 9'd2);
      repeat (4) send_word(1'b0, '0);

      // name count raised past the table size while mid-record
      set_config(1'b0, 32'h0, 9'd511);
      repeat (3) send_word(1'b0, '0);
      send_word(1'b1, '0);

      // one longer stream of data words with sparse bit errors
      set_config(1'b1, $urandom, 9'd1);
      for (int i = 0; i < 120; i++)
         send_word(1'b0, ($urandom_range(0, 199) == 0) ? (32'd1 << $urandom_range(0, 31)) : '0);
      send_word(1'b1, '0);

      // random phases; the first one runs against a long receiver hold-off
      random_items = 0;
      first = 1'b1;
      while (random_items < RAND_ITEMS) begin
         pick = $urandom_range(0, 11);
         if (pick == 0)      names = 9'd256;
         else if (pick == 1) names = 9'd511;
         else if (pick == 2) names = NAMES_W'($urandom_range(0, 511));
         else                names = NAMES_W'($urandom_range(0, 6));
         if ($urandom_range(0, 3) == 0) seed = $urandom_range(0, 1) ? '1 : '0;
         else                           seed = $urandom;
         set_config($urandom_range(0, 9) < 7, seed, names);
         if (first) begin
            hold_asks++;
            rush = 1'b1;
         end
         start_count = items_queued;
         len = $urandom_range(20, 70);
         if (name_span(cfg_now) > 16) len += name_span(cfg_now);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 8) begin
               send_load(INDEX_W'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)));
            end else begin
               flip = '0;
               if (cfg_now.mode && $urandom_range(0, 9) == 0) begin
                  if ($urandom_range(0, 1)) flip = 32'd1 << $urandom_range(0, 31);
                  else                      flip = $urandom;
                  if (flip == 0) flip = 32'd1;
               end
               send_word($urandom_range(0, 39) == 0, flip);
            end
         end
         if ($urandom_range(0, 1)) send_word(1'b1, '0);
         random_items += items_queued - start_count;
         if (first) begin
            wait_idle();
            rush  = 1'b0;
            first = 1'b0;
         end
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
